/* rtl/sdtq_pkg.sv */
// Package for the sorted deadline timer queue: request and status codes,
// default sizes and the per-cycle control word broadcast to the cell chain.
`default_nettype none
package sdtq_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int HANDLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_ADJUST = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_DUP      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK
    } state_t;

    // what every cell does this cycle
    typedef struct packed {
        logic do_remove;  // cells at or above the matching cell pull from the right
        logic do_insert;  // insert the new key at its sorted place
        logic do_pop;     // drop the head, everyone pulls from the right
    } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/sdtq_cell.sv */
// One slot of the sorted chain: holds a handle and a deadline and decides
// locally from its neighbors what to hold next. Uses sdtq_pkg.
`default_nettype none
module sdtq_cell
    import sdtq_pkg::*;
#(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_ctl_t              ctl,
    input  wire logic [HANDLE_BITS-1:0] key_handle,
    input  wire logic [TIME_BITS-1:0]   key_deadline,
    // left neighbor
    input  wire logic                   left_valid,
    input  wire logic                   left_goes_after,
    input  wire logic                   left_removed,
    input  wire logic [HANDLE_BITS-1:0] left_handle,
    input  wire logic [TIME_BITS-1:0]   left_deadline,
    // right neighbor
    input  wire logic                   right_valid,
    input  wire logic [HANDLE_BITS-1:0] right_handle,
    input  wire logic [TIME_BITS-1:0]   right_deadline,
    // own view
    output logic                        valid,
    output logic                        goes_after,
    output logic                        hit,
    output logic                        removed,
    output logic [HANDLE_BITS-1:0]      handle,
    output logic [TIME_BITS-1:0]        deadline
);

    logic                   valid_reg, valid_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [TIME_BITS-1:0]   deadline_reg, deadline_next;

    assign valid    = valid_reg;
    assign handle   = handle_reg;
    assign deadline = deadline_reg;
    assign hit      = valid_reg && (handle_reg == key_handle);
    // new key lands after this entry
    assign goes_after = valid_reg && (deadline_reg <= key_deadline);
    // this cell or one to its left matched the removed handle
    assign removed  = hit || left_removed;

    always_comb
    begin
        valid_next    = valid_reg;
        handle_next   = handle_reg;
        deadline_next = deadline_reg;
        if (ctl.do_pop || (ctl.do_remove && removed))
        begin
            valid_next    = right_valid;
            handle_next   = right_handle;
            deadline_next = right_deadline;
        end
        else if (ctl.do_insert)
        begin
            if (valid_reg && !goes_after)
            begin
                if (left_valid && !left_goes_after)
                begin
                    handle_next   = left_handle;
                    deadline_next = left_deadline;
                end
                else
                begin
                    handle_next   = key_handle;
                    deadline_next = key_deadline;
                end
            end
            else if (!valid_reg && left_valid)
            begin
                valid_next = 1'b1;
                if (!left_goes_after)
                begin
                    handle_next   = left_handle;
                    deadline_next = left_deadline;
                end
                else
                begin
                    handle_next   = key_handle;
                    deadline_next = key_deadline;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        handle_reg   <= handle_next;
        deadline_reg <= deadline_next;
    end

endmodule
`default_nettype wire

/* rtl/sorted_deadline_timer_queue.sv */
// Sorted deadline timer queue: a row of DEPTH cells kept in deadline order.
// An add or delete matches the handle, shifts the chain and registers its
// result in the execute state. An adjust that finds its handle passes the
// execute state twice, since the removal and the re-insert are two separate
// shifts. A tick gives one expired item per cycle with the head cell popped
// each time, or a single done result if the head is not yet due, and busy
// stays high until the last result is registered. Results come on the strobe
// for one cycle and cannot be held off. Uses sdtq_pkg.
`default_nettype none
module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             req_type,
    input  wire logic [HANDLE_BITS-1:0] handle,
    input  wire logic [TIME_BITS-1:0]   deadline,
    input  wire logic [TIME_BITS-1:0]   now_time,
    output logic                        strobe,
    output logic [2:0]                  status,
    output logic [HANDLE_BITS-1:0]      out_handle,
    output logic [TIME_BITS-1:0]        out_deadline,
    output logic                        last
);

    state_t state_reg, state_next;
    logic [1:0]             req_reg;
    logic [HANDLE_BITS-1:0] key_h_reg;
    logic [TIME_BITS-1:0]   key_d_reg, now_reg;
    logic                   ins_pend_reg, ins_pend_next;

    logic                   strobe_reg, strobe_next;
    logic [2:0]             status_reg, status_next;
    logic [HANDLE_BITS-1:0] oh_reg, oh_next;
    logic [TIME_BITS-1:0]   od_reg, od_next;
    logic                   last_reg, last_next;

    cell_ctl_t ctl;
    logic [DEPTH-1:0] c_valid, c_after, c_hit, c_rem;
    logic [HANDLE_BITS-1:0] c_h [DEPTH];
    logic [TIME_BITS-1:0]   c_d [DEPTH];

    // cell 0 sees a valid left neighbor that the key goes after, so an
    // insert at the head or into an empty chain takes the key
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            sdtq_cell #(.HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl            (ctl),
                .key_handle     (key_h_reg),
                .key_deadline   (key_d_reg),
                .left_valid     ((g == 0) ? 1'b1 : c_valid[(g == 0) ? 0 : g-1]),
                .left_goes_after((g == 0) ? 1'b1 : c_after[(g == 0) ? 0 : g-1]),
                .left_removed   ((g == 0) ? 1'b0 : c_rem[(g == 0) ? 0 : g-1]),
                .left_handle    (c_h[(g == 0) ? 0 : g-1]),
                .left_deadline  (c_d[(g == 0) ? 0 : g-1]),
                .right_valid    ((g == DEPTH-1) ? 1'b0 : c_valid[(g == DEPTH-1) ? g : g+1]),
                .right_handle   (c_h[(g == DEPTH-1) ? g : g+1]),
                .right_deadline (c_d[(g == DEPTH-1) ? g : g+1]),
                .valid          (c_valid[g]),
                .goes_after     (c_after[g]),
                .hit            (c_hit[g]),
                .removed        (c_rem[g]),
                .handle         (c_h[g]),
                .deadline       (c_d[g])
            );
        end
    endgenerate

    // the last cell is always the last to fill, so it being valid means full;
    // the head is cell 0
    logic any_hit, full, head_due;
    assign any_hit  = |c_hit;
    assign full     = c_valid[DEPTH-1];
    assign head_due = c_valid[0] && (c_d[0] <= now_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = (req_t'(req_type) == REQ_TICK) ? S_TICK : S_EXEC;
            S_EXEC:
                if (ins_pend_reg || !(req_t'(req_reg) == REQ_ADJUST && any_hit))
                    state_next = S_IDLE;
            S_TICK:
                if (!head_due || !c_valid[1] || (c_d[1] > now_reg))
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ins_pend_next = 1'b0;
        strobe_next   = 1'b0;
        status_next   = ST_DONE;
        oh_next       = key_h_reg;
        od_next       = '0;
        last_next     = 1'b1;
        case (state_reg)
            S_EXEC:
                if (ins_pend_reg)
                begin
                    ctl.do_insert = 1'b1;
                    strobe_next   = 1'b1;
                end
                else
                begin
                    case (req_t'(req_reg))
                        REQ_ADD:
                        begin
                            strobe_next = 1'b1;
                            if (any_hit)
                                status_next = ST_DUP;
                            else if (full)
                                status_next = ST_FULL;
                            else
                                ctl.do_insert = 1'b1;
                        end
                        REQ_DELETE, REQ_ADJUST:
                            if (!any_hit)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                ctl.do_remove = 1'b1;
                                ins_pend_next = (req_t'(req_reg) == REQ_ADJUST);
                                strobe_next   = (req_t'(req_reg) == REQ_DELETE);
                            end
                        default: ;
                    endcase
                end
            S_TICK:
            begin
                strobe_next = 1'b1;
                if (head_due)
                begin
                    ctl.do_pop  = 1'b1;
                    status_next = ST_EXPIRED;
                    oh_next     = c_h[0];
                    od_next     = c_d[0];
                    last_next   = !(c_valid[1] && (c_d[1] <= now_reg));
                end
                else
                    oh_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ins_pend_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ins_pend_reg <= ins_pend_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg   <= req_type;
            key_h_reg <= handle;
            key_d_reg <= deadline;
            now_reg   <= now_time;
        end
        status_reg <= status_next;
        oh_reg     <= oh_next;
        od_reg     <= od_next;
        last_reg   <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign out_handle   = oh_reg;
    assign out_deadline = od_reg;
    assign last         = last_reg;

    // valid cells always form a prefix of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        ((c_valid >> 1) & ~c_valid) == '0)
        else $error("valid cells not contiguous");
    // the key handle is held by at most one cell
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(c_hit))
        else $error("duplicate handle in chain");
    // every pop gives an expired result on the strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_pop |=> strobe && status == ST_EXPIRED)
        else $error("pop without expiry result");
    // a done-and-idle transition always delivers a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && state_next == S_IDLE) |=> (strobe && last))
        else $error("item ended without last result");

endmodule
`default_nettype wire
